### sv/eae_pkg.sv
// email address extractor: shared types, constants and character classes
// no dependencies
`timescale 1ns / 1ps

package eae_pkg;

    localparam int MAX_PREFIX_DEF = 20;
    localparam int MAX_SUFFIX_DEF = 40;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PREFIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUFFIX = 1'b1;

    localparam logic [4:0] MIN_PREFIX_RST = 5'd1;
    localparam logic [5:0] MIN_SUFFIX_RST = 6'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_block;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_address;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_RD,
        S_CNT_DAT,
        S_CHK,
        S_PRE_RD,
        S_PRE_DAT,
        S_AT,
        S_SUF_RD
    } eae_state_t;

    function automatic logic is_mail_char(input logic [7:0] b);
        logic r;
        begin
            if (b == CH_NUL)
            begin
                r = 1'b1;
            end
            else if (b <= CH_BANG || b >= CH_TILDE)
            begin
                r = 1'b0;
            end
            else
            begin
                unique case (b)
                    8'h40, 8'h27, 8'h22, 8'h3C, 8'h3E, 8'h3B, 8'h3A,
                    8'h5C, 8'h2F, 8'h3F, 8'h3D, 8'h26, 8'h28, 8'h29: r = 1'b0;
                    default: r = 1'b1;
                endcase
            end
            return r;
        end
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

endpackage

### sv/email_address_extractor_core.sv
// email address extractor top level: byte ring memory, capture tracking, emit sequencer
// depends on eae_pkg
`timescale 1ns / 1ps
//
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid / in_ready / in_beat    | one byte of a block + block end
//  out     | out_valid / out_ready / out_beat | one address character
//  cfg     | cfg_we / cfg_index / cfg_data    | register write, no handshake
//
//  bytes that close no suffix scan keep the block idle and stream back to back
//  a byte that closes a suffix scan stalls input for the prefix count pass, unless
//  the prefix is empty, then, if the capture passes its checks, for emission of
//  each character, paced by the registered read of the ring memory
//  reset clears control state only; the ring needs no clearing since counts
//  gate every read. a stalled output holds its register and the sequencer waits

module email_address_extractor_core #(
    parameter int MAX_PREFIX = eae_pkg::MAX_PREFIX_DEF,
    parameter int MAX_SUFFIX = eae_pkg::MAX_SUFFIX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  eae_pkg::in_beat_t                in_beat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output eae_pkg::out_beat_t               out_beat,
    input  logic                             cfg_we,
    input  logic [eae_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [eae_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import eae_pkg::*;

    // history window and suffix window sizes
    localparam int HIST_DEPTH = MAX_PREFIX + 1;
    localparam int SUF_DEPTH  = MAX_SUFFIX + 1;
    // ring holds a full prefix window plus a full suffix window
    localparam int AW         = $clog2(HIST_DEPTH + SUF_DEPTH + 1);
    localparam int RING_DEPTH = 1 << AW;
    localparam int PW         = $clog2(HIST_DEPTH + 1);
    localparam int DW         = $clog2(SUF_DEPTH + 1);
    localparam int RW         = (PW > DW) ? PW : DW;

    // ring memory of email-character bytes, nul stored as zero
    logic [7:0] ring_mem [RING_DEPTH];
    logic [7:0] rd_data_reg;

    eae_state_t state_reg, state_next;

    logic [4:0]    min_prefix_reg;
    logic [5:0]    min_suffix_reg;

    // write side and run tracking
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] run_len_reg, run_len_next;

    // live capture of the current at sign
    logic          cap_reg, cap_next;
    logic [AW-1:0] at_ptr_reg, at_ptr_next;
    logic [PW-1:0] pfx_len_reg, pfx_len_next;
    logic [DW-1:0] sfx_dist_reg, sfx_dist_next;
    logic [DW-1:0] sfx_cnt_reg, sfx_cnt_next;
    logic [DW-1:0] trim_reg, trim_next;
    logic          dot_seen_reg, dot_seen_next;
    logic          dot_trim_reg, dot_trim_next;
    logic          first_dot_reg, first_dot_next;

    // snapshot of a closed capture being judged and emitted
    logic [AW-1:0] fin_at_reg, fin_at_next;
    logic [PW-1:0] fin_len_reg, fin_len_next;
    logic [DW-1:0] fin_slen_reg, fin_slen_next;
    logic          fin_ok_reg, fin_ok_next;

    // sequencer
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    // suffix read phase: low while the read is in flight, high with data
    logic          sfx_phase_reg, sfx_phase_next;

    logic          out_valid_reg, out_valid_next;
    out_beat_t     out_beat_reg, out_beat_next;

    // step decode
    logic          acc, mail, nz, store, letter, done, can_load, pfx_ok;
    logic [DW-1:0] c_dist, c_cnt, c_trim;
    logic          c_dot_seen, c_dot_trim, c_first_dot;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    assign acc      = in_valid && in_ready;
    assign mail     = is_mail_char(in_beat.data_byte);
    assign nz       = (in_beat.data_byte != CH_NUL);
    assign store    = cap_reg && mail && nz;
    assign letter   = is_letter(in_beat.data_byte);
    assign can_load = !out_valid_reg || out_ready;

    // suffix tracking including this byte
    always_comb
    begin
        c_dist      = sfx_dist_reg + DW'(cap_reg && mail);
        c_cnt       = sfx_cnt_reg + DW'(store);
        c_trim      = (store && letter) ? sfx_cnt_reg + DW'(1) : trim_reg;
        c_dot_trim  = (store && letter) ? dot_seen_reg : dot_trim_reg;
        c_dot_seen  = dot_seen_reg || (store && in_beat.data_byte == CH_DOT);
        c_first_dot = (store && sfx_cnt_reg == '0) ? (in_beat.data_byte == CH_DOT)
                                                   : first_dot_reg;
        done        = cap_reg && (!mail || 32'(c_dist) >= 32'(SUF_DEPTH)
                                  || in_beat.last_in_block);
    end

    assign pfx_ok = (32'(pcnt_reg) >= 32'(min_prefix_reg))
                 && (32'(pcnt_reg) <= 32'(MAX_PREFIX));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && done)
                begin
                    state_next = (pfx_len_reg == '0) ? S_CHK : S_CNT_RD;
                end
            end
            S_CNT_RD:  state_next = S_CNT_DAT;
            S_CNT_DAT: state_next = (rem_reg == RW'(1)) ? S_CHK : S_CNT_RD;
            S_CHK:
            begin
                if (pfx_ok && fin_ok_reg)
                begin
                    state_next = (fin_len_reg == '0) ? S_AT : S_PRE_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PRE_RD: state_next = S_PRE_DAT;
            S_PRE_DAT:
            begin
                if (rd_data_reg == CH_NUL || can_load)
                begin
                    state_next = (rem_reg == RW'(1)) ? S_AT : S_PRE_RD;
                end
            end
            S_AT:
            begin
                if (can_load)
                begin
                    state_next = S_SUF_RD;
                end
            end
            S_SUF_RD:
            begin
                // a read gap is folded in: the sub-phase sfx_phase, set in the datapath
                // below, goes high once the registered read data is in rd_data_reg
                state_next = S_SUF_RD;
                if (sfx_phase_reg && (rd_data_reg == CH_NUL || can_load)
                    && rd_data_reg != CH_NUL && rem_reg == RW'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        wptr_next      = wptr_reg;
        run_len_next   = run_len_reg;
        cap_next       = cap_reg;
        at_ptr_next    = at_ptr_reg;
        pfx_len_next   = pfx_len_reg;
        sfx_dist_next  = sfx_dist_reg;
        sfx_cnt_next   = sfx_cnt_reg;
        trim_next      = trim_reg;
        dot_seen_next  = dot_seen_reg;
        dot_trim_next  = dot_trim_reg;
        first_dot_next = first_dot_reg;
        fin_at_next    = fin_at_reg;
        fin_len_next   = fin_len_reg;
        fin_slen_next  = fin_slen_reg;
        fin_ok_next    = fin_ok_reg;
        rd_ptr_next    = rd_ptr_reg;
        rem_next       = rem_reg;
        pcnt_next      = pcnt_reg;
        sfx_phase_next = sfx_phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_beat_next  = out_beat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (cap_reg)
                    begin
                        sfx_dist_next  = c_dist;
                        sfx_cnt_next   = c_cnt;
                        trim_next      = c_trim;
                        dot_seen_next  = c_dot_seen;
                        dot_trim_next  = c_dot_trim;
                        first_dot_next = c_first_dot;
                    end
                    if (done)
                    begin
                        cap_next      = 1'b0;
                        fin_at_next   = at_ptr_reg;
                        fin_len_next  = pfx_len_reg;
                        fin_slen_next = c_trim;
                        fin_ok_next   = (32'(c_trim) >= 32'(min_suffix_reg))
                                     && (32'(c_trim) <= 32'(MAX_SUFFIX))
                                     && c_dot_trim && !c_first_dot;
                        rd_ptr_next   = at_ptr_reg - AW'(pfx_len_reg);
                        rem_next      = RW'(pfx_len_reg);
                        pcnt_next     = '0;
                    end
                    if (in_beat.data_byte == CH_AT)
                    begin
                        at_ptr_next    = wptr_reg;
                        pfx_len_next   = run_len_reg;
                        sfx_dist_next  = '0;
                        sfx_cnt_next   = '0;
                        trim_next      = '0;
                        dot_seen_next  = 1'b0;
                        dot_trim_next  = 1'b0;
                        first_dot_next = 1'b0;
                        cap_next       = !in_beat.last_in_block;
                    end
                    if (mail)
                    begin
                        wptr_next = wptr_reg + AW'(1);
                        if (32'(run_len_reg) < HIST_DEPTH)
                        begin
                            run_len_next = run_len_reg + PW'(1);
                        end
                    end
                    else
                    begin
                        run_len_next = '0;
                    end
                    if (in_beat.last_in_block)
                    begin
                        run_len_next = '0;
                    end
                end
            end
            S_CNT_RD:
            begin
            end
            S_CNT_DAT:
            begin
                pcnt_next   = pcnt_reg + PW'(rd_data_reg != CH_NUL);
                rem_next    = rem_reg - RW'(1);
                rd_ptr_next = rd_ptr_reg + AW'(1);
            end
            S_CHK:
            begin
                rd_ptr_next = fin_at_reg - AW'(fin_len_reg);
                rem_next    = RW'(fin_len_reg);
            end
            S_PRE_RD:
            begin
            end
            S_PRE_DAT:
            begin
                if (rd_data_reg == CH_NUL || can_load)
                begin
                    rem_next    = rem_reg - RW'(1);
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                    if (rd_data_reg != CH_NUL)
                    begin
                        out_valid_next                = 1'b1;
                        out_beat_next.out_char        = rd_data_reg;
                        out_beat_next.last_of_address = 1'b0;
                    end
                end
            end
            S_AT:
            begin
                if (can_load)
                begin
                    out_valid_next                = 1'b1;
                    out_beat_next.out_char        = CH_AT;
                    out_beat_next.last_of_address = 1'b0;
                    rem_next                      = RW'(fin_slen_reg);
                    rd_ptr_next                   = fin_at_reg;
                    sfx_phase_next                = 1'b0;
                end
            end
            S_SUF_RD:
            begin
                if (!sfx_phase_reg)
                begin
                    sfx_phase_next = 1'b1;
                end
                else if (rd_data_reg == CH_NUL)
                begin
                    rd_ptr_next    = rd_ptr_reg + AW'(1);
                    sfx_phase_next = 1'b0;
                end
                else if (can_load)
                begin
                    out_valid_next                = 1'b1;
                    out_beat_next.out_char        = rd_data_reg;
                    out_beat_next.last_of_address = (rem_reg == RW'(1));
                    rem_next                      = rem_reg - RW'(1);
                    rd_ptr_next                   = rd_ptr_reg + AW'(1);
                    sfx_phase_next                = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ring memory: write on accepted email characters, registered read
    always_ff @(posedge clk)
    begin
        if (acc && mail)
        begin
            ring_mem[wptr_reg] <= in_beat.data_byte;
        end
        rd_data_reg <= ring_mem[rd_ptr_next];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            min_prefix_reg <= MIN_PREFIX_RST;
            min_suffix_reg <= MIN_SUFFIX_RST;
            wptr_reg       <= '0;
            run_len_reg    <= '0;
            cap_reg        <= 1'b0;
            pfx_len_reg    <= '0;
            sfx_dist_reg   <= '0;
            sfx_cnt_reg    <= '0;
            trim_reg       <= '0;
            rem_reg        <= '0;
            pcnt_reg       <= '0;
            sfx_phase_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            run_len_reg   <= run_len_next;
            cap_reg       <= cap_next;
            pfx_len_reg   <= pfx_len_next;
            sfx_dist_reg  <= sfx_dist_next;
            sfx_cnt_reg   <= sfx_cnt_next;
            trim_reg      <= trim_next;
            rem_reg       <= rem_next;
            pcnt_reg      <= pcnt_next;
            sfx_phase_reg <= sfx_phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_PREFIX: min_prefix_reg <= cfg_data[4:0];
                    CFG_MIN_SUFFIX: min_suffix_reg <= cfg_data[5:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        at_ptr_reg    <= at_ptr_next;
        dot_seen_reg  <= dot_seen_next;
        dot_trim_reg  <= dot_trim_next;
        first_dot_reg <= first_dot_next;
        fin_at_reg    <= fin_at_next;
        fin_len_reg   <= fin_len_next;
        fin_slen_reg  <= fin_slen_next;
        fin_ok_reg    <= fin_ok_next;
        rd_ptr_reg    <= rd_ptr_next;
        out_beat_reg  <= out_beat_next;
    end

endmodule

### sv/eae_checker.sv
// port-level checks for the email address extractor, bound to the top level
// depends on eae_pkg and email_address_extractor_core
`timescale 1ns / 1ps

module eae_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input eae_pkg::out_beat_t  out_beat
);
    import eae_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("output beat changed while stalled");

    // nul is never emitted
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_beat.out_char != CH_NUL)
        else $error("nul character emitted");

    // the at sign never closes an address
    a_at_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.out_char == CH_AT |-> !out_beat.last_of_address)
        else $error("address closed on at sign");

    // input is held off when an output beat that does not close an address first becomes valid
    a_stall_mid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !out_beat.last_of_address |-> !in_ready)
        else $error("input taken in the middle of an address");

endmodule

bind email_address_extractor_core eae_checker u_eae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
);
